[hdl/kdef_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package kdef_pkg;

  localparam int NUM_KEYS_DEF   = 3;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int REG_KEYS       = 3;   // keys that own long/repeat registers

  localparam int FILTER_W   = 7;
  localparam int LONG_W     = 16;
  localparam int SPEED_W    = 8;
  localparam int DCOUNT_W   = 8;
  localparam int CODE_W     = 8;
  localparam int REQ_W      = 3;
  localparam int KEY_OUT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int RESET_FILTER_VAL = 5;
  localparam logic [FILTER_W-1:0] RESET_FILTER = FILTER_W'(RESET_FILTER_VAL);
  localparam logic [DCOUNT_W-1:0] RESET_DCOUNT = DCOUNT_W'(RESET_FILTER_VAL / 2);
  localparam logic [LONG_W-1:0]   RESET_LONG   = LONG_W'(100);

  // request kinds
  localparam logic [REQ_W-1:0] REQ_TICK        = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ_MAIN   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ_SECOND = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PUSH        = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR_MAIN  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_0 = 3'd4;

  // event code = key * EVT_STRIDE + offset
  localparam int EVT_STRIDE      = 3;
  localparam int EVT_REPEAT_OFS  = 1;  // click and repeat
  localparam int EVT_RELEASE_OFS = 2;
  localparam int EVT_LONG_OFS    = 3;

  typedef struct packed {
    logic [DCOUNT_W-1:0] dcount;
    logic                pressed;
    logic [LONG_W-1:0]   hold;
    logic [SPEED_W-1:0]  rep;
  } key_state_t;

  typedef struct packed {
    logic              first_vld;
    logic [CODE_W-1:0] first_code;
    logic              second_vld;
    logic [CODE_W-1:0] second_code;
  } key_evt_t;

  typedef struct packed {
    logic en;
    logic rd_main;
    logic rd_second;
    logic clear_main;
  } fifo_ctl_t;

endpackage
`default_nettype wire

[hdl/kdef_key_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
module kdef_key_scan
  import kdef_pkg::*;
#(
  parameter int KEY_IDX = 0
) (
  input  wire logic                down,
  input  wire logic [FILTER_W-1:0] ft,
  input  wire logic [LONG_W-1:0]   long_time,
  input  wire logic [SPEED_W-1:0]  rep_speed,
  input  wire key_state_t          st,
  output key_state_t               st_nxt,
  output key_evt_t                 evt
);

  localparam logic [CODE_W-1:0] CODE_LONG    = CODE_W'(KEY_IDX * EVT_STRIDE + EVT_LONG_OFS);
  localparam logic [CODE_W-1:0] CODE_REPEAT  = CODE_W'(KEY_IDX * EVT_STRIDE + EVT_REPEAT_OFS);
  localparam logic [CODE_W-1:0] CODE_RELEASE = CODE_W'(KEY_IDX * EVT_STRIDE + EVT_RELEASE_OFS);

  logic [DCOUNT_W-1:0] ft_ext;
  logic [DCOUNT_W-1:0] ft_dbl;
  logic [LONG_W-1:0]   ft_long;
  logic [LONG_W-1:0]   hold_inc;
  logic [SPEED_W-1:0]  rep_inc;

  always_comb begin
    ft_ext   = {1'b0, ft};
    ft_dbl   = {ft, 1'b0};
    ft_long  = {{(LONG_W-FILTER_W){1'b0}}, ft};
    hold_inc = st.hold + LONG_W'(1);
    rep_inc  = st.rep + SPEED_W'(1);

    st_nxt          = st;
    evt.first_vld   = 1'b0;
    evt.first_code  = CODE_LONG;
    evt.second_vld  = 1'b0;
    evt.second_code = CODE_RELEASE;

    if (down) begin
      if (st.dcount < ft_ext) begin
        st_nxt.dcount = ft_ext;
      end else if (st.dcount < ft_dbl) begin
        st_nxt.dcount = st.dcount + DCOUNT_W'(1);
      end else begin
        st_nxt.pressed = 1'b1;
        if (long_time != '0) begin
          if (st.hold < long_time) begin
            st_nxt.hold = hold_inc;
            if (hold_inc == long_time) begin
              evt.first_vld = 1'b1;
            end
          end else if (rep_speed != '0) begin
            if (rep_inc >= rep_speed) begin
              st_nxt.rep     = '0;
              evt.first_vld  = 1'b1;
              evt.first_code = CODE_REPEAT;
            end else begin
              st_nxt.rep = rep_inc;
            end
          end
        end
      end
    end else begin
      // click: released after the filter time but before the long time
      if ((st.hold < long_time) && (st.hold > ft_long)) begin
        evt.first_vld  = 1'b1;
        evt.first_code = CODE_REPEAT;
      end
      if (st.dcount > ft_ext) begin
        st_nxt.dcount = ft_ext;
      end else if (st.dcount != '0) begin
        st_nxt.dcount = st.dcount - DCOUNT_W'(1);
      end else if (st.pressed) begin
        st_nxt.pressed = 1'b0;
        evt.second_vld = 1'b1;
      end
      st_nxt.hold = '0;
      st_nxt.rep  = '0;
    end
  end

endmodule
`default_nettype wire

[hdl/kdef_event_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module kdef_event_fifo
  import kdef_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int NUM_WR     = 2 * NUM_KEYS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire fifo_ctl_t                      ctl,
  input  wire logic [NUM_WR-1:0]              wr_vld,
  input  wire logic [NUM_WR-1:0][CODE_W-1:0]  wr_code,
  output logic [CODE_W-1:0]                   rd_code,
  output logic                                main_empty_nxt
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [CODE_W-1:0] store_r [FIFO_DEPTH];
  logic [CODE_W-1:0] rd_code_r;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  mrp_r, mrp_nxt;
  logic [PTR_W-1:0]  srp_r, srp_nxt;
  logic [PTR_W-1:0]  wr_idx [NUM_WR+1];
  logic [PTR_W-1:0]  rd_ptr;
  logic              rd_empty;
  logic              rd_hit;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    // write slots land in order, each one after the last
    wr_idx[0] = wp_r;
    for (int n = 0; n < NUM_WR; n++) begin
      wr_idx[n+1] = wr_vld[n] ? ptr_next(wr_idx[n]) : wr_idx[n];
    end
    wp_nxt = ctl.en ? wr_idx[NUM_WR] : wp_r;

    rd_ptr   = ctl.rd_main ? mrp_r : srp_r;
    rd_empty = (rd_ptr == wp_r);
    rd_hit   = (ctl.rd_main || ctl.rd_second) && !rd_empty;

    mrp_nxt = mrp_r;
    srp_nxt = srp_r;
    if (ctl.en) begin
      if (ctl.rd_main && !rd_empty) begin
        mrp_nxt = ptr_next(mrp_r);
      end
      if (ctl.rd_second && !rd_empty) begin
        srp_nxt = ptr_next(srp_r);
      end
      if (ctl.clear_main) begin
        mrp_nxt = wp_r;
      end
    end
    main_empty_nxt = (mrp_nxt == wp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      mrp_r <= '0;
      srp_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      mrp_r <= mrp_nxt;
      srp_r <= srp_nxt;
    end
  end

  // later slots win when the pointer wraps onto the same entry;
  // the read code loads alongside the result register
  always_ff @(posedge clk) begin
    for (int n = 0; n < NUM_WR; n++) begin
      if (ctl.en && wr_vld[n]) begin
        store_r[wr_idx[n]] <= wr_code[n];
      end
    end
    if (ctl.en) begin
      rd_code_r <= rd_hit ? store_r[rd_ptr] : '0;
    end
  end

  assign rd_code = rd_code_r;

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.en && ctl.clear_main) |=> (mrp_r == wp_r))
    else $error("main pointer not at write pointer after clear");

  a_empty_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.en && ctl.rd_main && (mrp_r == wp_r)) |=> $stable(mrp_r))
    else $error("main pointer moved on empty read");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.en && (ctl.rd_main || ctl.rd_second) && rd_empty) |=> (rd_code == '0))
    else $error("empty read returned a code");

endmodule
`default_nettype wire

[hdl/key_debounce_event_fifo_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// A taken request word passes from the input register to the result register, which drives out_.
// Throughput: one request word per cycle; the input register and the result register
//   form a two-stage pipeline, stalled only by out_tready.
// Every request, a tick scanning all keys included, completes in one pass of logic.
// Reset (rst_n low, synchronous): pipeline empty, pointers zero, registers at defaults,
//   debounce counters at half the default filter time. FIFO contents are not cleared.
module key_debounce_event_fifo_core
  import kdef_pkg::*;
#(
  parameter int NUM_KEYS   = NUM_KEYS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // [2:0] keys_down, [10:3] push_code
  input  wire logic [REQ_W-1:0]      in_tuser,   // [2:0] req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [15:0]                out_tdata,  // [7:0] read_code, [10:8] key_states,
                                                 // [11] main_empty
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_WR = 2 * NUM_KEYS;   // each key may post two codes per tick

  // ---------------- input register ----------------
  logic                 s1_vld_r, s1_vld_nxt;
  logic [REQ_W-1:0]     s1_req_r;
  logic [KEY_OUT_W-1:0] s1_keys_r;
  logic [CODE_W-1:0]    s1_code_r;
  logic                 s1_go;
  logic                 in_acc;

  // ---------------- result register ----------------
  // read_code is registered inside the FIFO next to its store; upper bits here
  logic              out_vld_r, out_vld_nxt;
  logic [15:CODE_W]  out_data_r;

  // ---------------- configuration ----------------
  logic [FILTER_W-1:0] filter_r;
  logic [LONG_W-1:0]   long_r  [REG_KEYS];
  logic [SPEED_W-1:0]  speed_r [REG_KEYS];
  logic                cfg_wr;

  // ---------------- key state ----------------
  key_state_t key_r    [NUM_KEYS];
  key_state_t key_nxt  [NUM_KEYS];
  key_state_t scan_nxt [NUM_KEYS];
  key_evt_t   key_evt  [NUM_KEYS];
  logic [NUM_KEYS-1:0] cfg_key_hit;

  logic                          is_tick;
  fifo_ctl_t                     fifo_ctl;
  logic [NUM_WR-1:0]             wr_vld;
  logic [NUM_WR-1:0][CODE_W-1:0] wr_code;
  logic [CODE_W-1:0]             rd_code;
  logic                          main_empty_nxt;
  logic [KEY_OUT_W-1:0]          key_states;

  // Stage 1 moves on whenever the result register is free or being drained.
  assign s1_go     = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s1_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= in_tuser;
      s1_keys_r <= in_tdata[2:0];
      s1_code_r <= in_tdata[10:3];
    end
    if (s1_go) begin
      out_data_r <= {4'b0000, main_empty_nxt, key_states};
    end
  end

  // Register writes; long and repeat writes also restart that key's repeat count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= RESET_FILTER;
      for (int k = 0; k < REG_KEYS; k++) begin
        long_r[k]  <= RESET_LONG;
        speed_r[k] <= '0;
      end
    end else if (cfg_wr) begin
      if (cfg_index == CFG_FILTER) begin
        filter_r <= cfg_data[FILTER_W-1:0];
      end
      for (int k = 0; k < REG_KEYS; k++) begin
        if (cfg_index == CFG_IDX_W'(CFG_LONG_0 + k)) begin
          long_r[k] <= cfg_data;
        end
        if (cfg_index == CFG_IDX_W'(CFG_REPEAT_0 + k)) begin
          speed_r[k] <= cfg_data[SPEED_W-1:0];
        end
      end
    end
  end

  assign is_tick = s1_go && (s1_req_r == REQ_TICK);

  // Per-key scan; keys past the register set keep default long time and no repeat.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic                down;
    logic [LONG_W-1:0]   long_k;
    logic [SPEED_W-1:0]  speed_k;

    if (k < REG_KEYS) begin : g_reg
      assign long_k      = long_r[k];
      assign speed_k     = speed_r[k];
      assign cfg_key_hit[k] = cfg_wr && ((cfg_index == CFG_IDX_W'(CFG_LONG_0 + k)) ||
                                         (cfg_index == CFG_IDX_W'(CFG_REPEAT_0 + k)));
    end else begin : g_fixed
      assign long_k      = RESET_LONG;
      assign speed_k     = '0;
      assign cfg_key_hit[k] = 1'b0;
    end

    if (k < KEY_OUT_W) begin : g_in
      assign down = s1_keys_r[k];
    end else begin : g_none
      assign down = 1'b0;
    end

    kdef_key_scan #(
      .KEY_IDX (k)
    ) u_scan (
      .down      (down),
      .ft        (filter_r),
      .long_time (long_k),
      .rep_speed (speed_k),
      .st        (key_r[k]),
      .st_nxt    (scan_nxt[k]),
      .evt       (key_evt[k])
    );

    always_comb begin
      key_nxt[k] = is_tick ? scan_nxt[k] : key_r[k];
      if (cfg_key_hit[k]) begin
        key_nxt[k].rep = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_r[k].dcount  <= RESET_DCOUNT;
        key_r[k].pressed <= 1'b0;
        key_r[k].hold    <= '0;
        key_r[k].rep     <= '0;
      end else begin
        key_r[k] <= key_nxt[k];
      end
    end

    // write slots in scan order: click/long/repeat before release
    always_comb begin
      wr_vld[2*k]    = is_tick && key_evt[k].first_vld;
      wr_code[2*k]   = key_evt[k].first_code;
      wr_vld[2*k+1]  = is_tick && key_evt[k].second_vld;
      wr_code[2*k+1] = key_evt[k].second_code;
      if ((k == 0) && (s1_req_r == REQ_PUSH)) begin
        wr_vld[2*k]  = 1'b1;
        wr_code[2*k] = s1_code_r;
      end
    end
  end

  for (genvar k = 0; k < KEY_OUT_W; k++) begin : g_state
    if (k < NUM_KEYS) begin : g_on
      assign key_states[k] = key_nxt[k].pressed;
    end else begin : g_off
      assign key_states[k] = 1'b0;
    end
  end

  always_comb begin
    fifo_ctl.en         = s1_go;
    fifo_ctl.rd_main    = (s1_req_r == REQ_READ_MAIN);
    fifo_ctl.rd_second  = (s1_req_r == REQ_READ_SECOND);
    fifo_ctl.clear_main = (s1_req_r == REQ_CLEAR_MAIN);
  end

  kdef_event_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .NUM_WR     (NUM_WR)
  ) u_fifo (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (fifo_ctl),
    .wr_vld         (wr_vld),
    .wr_code        (wr_code),
    .rd_code        (rd_code),
    .main_empty_nxt (main_empty_nxt)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_data_r, rd_code};

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are stalled");

  a_nonread_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_req_r != REQ_READ_MAIN) && (s1_req_r != REQ_READ_SECOND))
      |=> (out_tdata[7:0] == '0))
    else $error("non-read request returned a code");

endmodule
`default_nettype wire

[sim/tb_key_debounce_event_fifo_core.sv]
`timescale 1ns / 1ps
module tb_key_debounce_event_fifo_core;
  import kdef_pkg::*;

  localparam int NUM_KEYS    = NUM_KEYS_DEF;
  localparam int FIFO_DEPTH  = FIFO_DEPTH_DEF;
  localparam int SCAN_KEYS   = 3;          // keys that have a bit in keys_down
  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_SHOWN   = 10;

  // request kinds 5..7 are spare: no state change, read_code 0
  localparam logic [REQ_W-1:0]     REQ_SPARE_FIRST = REQ_CLEAR_MAIN + 3'd1;
  // index past the last repeat register: write is dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = CFG_IDX_W'(CFG_REPEAT_0 + REG_KEYS);

  // one result word, fields top down so it lines up with out_tdata[11:0]
  typedef struct packed {
    logic                 main_empty;
    logic [KEY_OUT_W-1:0] key_states;
    logic [CODE_W-1:0]    read_code;
  } key_report_t;

  // Tracks the scanner and the shared event FIFO, and holds the reports still due.
  class key_event_scoreboard;
    logic [FILTER_W-1:0] filter_time;
    logic [LONG_W-1:0]   long_time [NUM_KEYS];
    logic [SPEED_W-1:0]  repeat_speed [NUM_KEYS];
    logic [DCOUNT_W-1:0] dcount [NUM_KEYS];
    logic                pressed [NUM_KEYS];
    logic [LONG_W-1:0]   hold [NUM_KEYS];
    logic [SPEED_W-1:0]  rep [NUM_KEYS];
    logic [CODE_W-1:0]   fifo_mem [FIFO_DEPTH];
    int                  wr_ptr;
    int                  main_ptr;
    int                  second_ptr;
    key_report_t         due_reports [$];
    int unsigned         bad_fields;

    function new();
      filter_time = RESET_FILTER;
      for (int k = 0; k < NUM_KEYS; k++) begin
        long_time[k]    = RESET_LONG;
        repeat_speed[k] = '0;
        dcount[k]       = RESET_DCOUNT;
        pressed[k]      = 1'b0;
        hold[k]         = '0;
        rep[k]          = '0;
      end
      wr_ptr     = 0;
      main_ptr   = 0;
      second_ptr = 0;
      bad_fields = 0;
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      int k;
      if (idx == CFG_FILTER) begin
        filter_time = value[FILTER_W-1:0];
      end else if (idx >= CFG_LONG_0 && idx < CFG_LONG_0 + REG_KEYS) begin
        k = idx - CFG_LONG_0;
        if (k < NUM_KEYS) begin
          long_time[k] = value[LONG_W-1:0];
          rep[k]       = '0;
        end
      end else if (idx >= CFG_REPEAT_0 && idx < CFG_REPEAT_0 + REG_KEYS) begin
        k = idx - CFG_REPEAT_0;
        if (k < NUM_KEYS) begin
          repeat_speed[k] = value[SPEED_W-1:0];
          rep[k]          = '0;
        end
      end
    endfunction

    // no full check: a wrap onto a read pointer silently drops its unread words
    function void push(logic [CODE_W-1:0] code);
      fifo_mem[wr_ptr] = code;
      wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
    endfunction

    function logic [CODE_W-1:0] take(bit from_second);
      int                p;
      logic [CODE_W-1:0] code;
      p = from_second ? second_ptr : main_ptr;
      if (p == wr_ptr) return '0;
      code = fifo_mem[p];
      p = (p + 1) % FIFO_DEPTH;
      if (from_second) second_ptr = p;
      else main_ptr = p;
      return code;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [2:0] keys,
                               logic [CODE_W-1:0] code);
      key_report_t r;
      int          ft;
      int          ft2;
      int          base;
      r   = '0;
      ft  = filter_time;
      ft2 = 2 * ft;
      case (req)
        REQ_TICK: begin
          for (int k = 0; k < NUM_KEYS; k++) begin
            base = EVT_STRIDE * k;
            if (k < SCAN_KEYS && keys[k]) begin
              // climb through the band; pressed once at the top
              if (dcount[k] < ft) begin
                dcount[k] = DCOUNT_W'(ft);
              end else if (dcount[k] < ft2) begin
                dcount[k] = dcount[k] + 1'b1;
              end else begin
                pressed[k] = 1'b1;
                if (long_time[k] != 0) begin
                  if (hold[k] < long_time[k]) begin
                    hold[k] = hold[k] + 1'b1;
                    if (hold[k] == long_time[k]) push(CODE_W'(base + EVT_LONG_OFS));
                  end else if (repeat_speed[k] != 0) begin
                    rep[k] = rep[k] + 1'b1;
                    if (rep[k] >= repeat_speed[k]) begin
                      rep[k] = '0;
                      push(CODE_W'(base + EVT_REPEAT_OFS));
                    end
                  end
                end
              end
            end else begin
              // click is judged before the counter moves, so it precedes a release
              if (hold[k] < long_time[k] && hold[k] > ft) push(CODE_W'(base + EVT_REPEAT_OFS));
              if (dcount[k] > ft) begin
                dcount[k] = DCOUNT_W'(ft);
              end else if (dcount[k] != 0) begin
                dcount[k] = dcount[k] - 1'b1;
              end else if (pressed[k]) begin
                pressed[k] = 1'b0;
                push(CODE_W'(base + EVT_RELEASE_OFS));
              end
              hold[k] = '0;
              rep[k]  = '0;
            end
          end
        end
        REQ_READ_MAIN:   r.read_code = take(1'b0);
        REQ_READ_SECOND: r.read_code = take(1'b1);
        REQ_PUSH:        push(code);
        REQ_CLEAR_MAIN:  main_ptr = wr_ptr;
        default: ;
      endcase
      for (int k = 0; k < NUM_KEYS && k < KEY_OUT_W; k++) r.key_states[k] = pressed[k];
      r.main_empty = (main_ptr == wr_ptr);
      due_reports.push_back(r);
    endfunction

    function void note_bad(string field, int unsigned want, int unsigned got);
      bad_fields++;
      if (bad_fields <= MAX_SHOWN)
        $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_report(logic [15:0] word);
      key_report_t want;
      if (due_reports.size() == 0) begin
        note_bad("word with nothing due", 0, word);
        return;
      end
      want = due_reports.pop_front();
      if (word[7:0] !== want.read_code)   note_bad("read_code", want.read_code, word[7:0]);
      if (word[10:8] !== want.key_states) note_bad("key_states", want.key_states, word[10:8]);
      if (word[11] !== want.main_empty)   note_bad("main_empty", want.main_empty, word[11]);
    endfunction

    function int pending();
      return due_reports.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [2:0] keys_down, [10:3] push_code
  logic [REQ_W-1:0]      in_tuser;   // [2:0] req_type
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;  // [7:0] read_code, [10:8] key_states, [11] main_empty
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  key_event_scoreboard sb;
  int unsigned         cycle_count = 0;
  bit                  gap_on;      // sender idles between words
  bit                  stall_on;    // receiver stalls between words
  logic [2:0]          held;        // intended key levels for well-formed presses
  int                  hold_left [SCAN_KEYS];

  key_debounce_event_fifo_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // every word taken on the result side is checked against the oldest report due
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata);
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("key_debounce_event_fifo_core: mismatch");
    $finish;
  end

  // One request word. Starts just after the previous acceptance edge, so valid
  // only drops when a gap is actually drawn.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [2:0] keys,
                              input logic [CODE_W-1:0] code);
    int unsigned gap;
    gap = gap_on ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {5'b0, code, keys};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(req, keys, code);
  endtask

  task automatic run_receiver();
    int unsigned stall;
    forever begin
      stall = stall_on ? $urandom_range(0, 8) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_config(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold off the sender until every report is back, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_all(input logic [FILTER_W-1:0] f, input logic [LONG_W-1:0] lt [SCAN_KEYS],
                           input logic [SPEED_W-1:0] sp [SCAN_KEYS]);
    write_reg(CFG_FILTER, CFG_DATA_W'(f));
    for (int k = 0; k < REG_KEYS; k++) begin
      write_reg(CFG_IDX_W'(CFG_LONG_0 + k), CFG_DATA_W'(lt[k]));
      write_reg(CFG_IDX_W'(CFG_REPEAT_0 + k), CFG_DATA_W'(sp[k]));
    end
  endtask

  // Mostly ticks that follow held press/release runs of random length; short
  // runs act as bounce, and now and then the key pattern is pure noise.
  // Reads never hit an unwritten entry: a pointer only trails the write pointer
  // over written words, and after the first wrap every entry has been written.
  task automatic send_random_item();
    int unsigned pick;
    logic [2:0]  keys;
    pick = $urandom_range(0, 99);
    if (pick < 64) begin
      for (int k = 0; k < SCAN_KEYS; k++) begin
        if (hold_left[k] == 0) begin
          held[k] = ~held[k];
          hold_left[k] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                                     : $urandom_range(4, 45);
        end
        hold_left[k]--;
      end
      keys = ($urandom_range(0, 24) == 0) ? 3'($urandom) : held;
      send_request(REQ_TICK, keys, 8'($urandom));
    end else if (pick < 77) begin
      send_request(REQ_READ_MAIN, 3'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      send_request(REQ_READ_SECOND, 3'($urandom), 8'($urandom));
    end else if (pick < 95) begin
      send_request(REQ_PUSH, 3'($urandom), 8'($urandom));
    end else if (pick < 98) begin
      send_request(REQ_CLEAR_MAIN, 3'($urandom), 8'($urandom));
    end else begin
      send_request(REQ_W'(REQ_SPARE_FIRST + $urandom_range(0, 2)), 3'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [FILTER_W-1:0] f;
    logic [LONG_W-1:0]   lt [SCAN_KEYS];
    logic [SPEED_W-1:0]  sp [SCAN_KEYS];

    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_TICK;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_FILTER;
    cfg_data   = '0;
    held       = '0;
    for (int k = 0; k < SCAN_KEYS; k++) hold_left[k] = 0;
    gap_on     = 1'b1;
    stall_on   = 1'b1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      run_receiver();
    join_none

    // --- directed, reset settings: spare kinds, empty reads, code zero, clear
    send_request(REQ_SPARE_FIRST, 3'b111, 8'hFF);
    send_request(REQ_W'(REQ_SPARE_FIRST + 1), 3'b000, 8'h00);
    send_request(REQ_W'(REQ_SPARE_FIRST + 2), 3'b101, 8'hA5);
    send_request(REQ_READ_MAIN, 3'b111, 8'hFF);
    send_request(REQ_READ_SECOND, 3'b000, 8'h00);
    send_request(REQ_PUSH, 3'b000, 8'h00);
    send_request(REQ_PUSH, 3'b111, 8'hFF);
    send_request(REQ_READ_MAIN, 3'b000, 8'h00);     // code zero reads as none
    send_request(REQ_READ_MAIN, 3'b000, 8'h00);
    send_request(REQ_READ_SECOND, 3'b000, 8'h00);
    send_request(REQ_PUSH, 3'b010, 8'h5A);
    send_request(REQ_CLEAR_MAIN, 3'b000, 8'h00);
    send_request(REQ_READ_MAIN, 3'b000, 8'h00);
    send_request(REQ_TICK, 3'b111, 8'h00);          // counters jump to the band floor
    wait_idle();

    // narrow band with counters left above it; long, repeat and disabled keys
    lt = '{16'd2, 16'd0, 16'hFFFF};
    sp = '{8'd1, 8'hFF, 8'd0};
    write_all(7'd1, lt, sp);
    write_reg(CFG_UNUSED, 16'hFFFF);
    repeat (6) send_request(REQ_TICK, 3'b111, 8'h00);
    repeat (3) send_request(REQ_TICK, 3'b000, 8'h00);  // clamp, count down, release
    wait_idle();

    // zero filter: press on the first down tick, click and release on one up tick
    write_reg(CFG_FILTER, '0);
    send_request(REQ_TICK, 3'b001, 8'h00);
    send_request(REQ_TICK, 3'b000, 8'h00);
    send_request(REQ_READ_MAIN, 3'b000, 8'h00);
    send_request(REQ_READ_MAIN, 3'b000, 8'h00);

    // --- random phases, each behind a full drain so settings only change at rest
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      if (phase == 2) begin
        f = '1;
        for (int k = 0; k < SCAN_KEYS; k++) begin
          lt[k] = '1;
          sp[k] = '1;
        end
      end else if (phase == 5) begin
        f = '0;
        for (int k = 0; k < SCAN_KEYS; k++) begin
          lt[k] = LONG_W'(k);
          sp[k] = (k == 1) ? '1 : SPEED_W'(k);
        end
      end else begin
        f = ($urandom_range(0, 5) == 0) ? FILTER_W'($urandom) : FILTER_W'($urandom_range(0, 4));
        for (int k = 0; k < SCAN_KEYS; k++) begin
          lt[k] = ($urandom_range(0, 7) == 0) ? LONG_W'($urandom) : LONG_W'($urandom_range(0, 24));
          sp[k] = ($urandom_range(0, 7) == 0) ? SPEED_W'($urandom) : SPEED_W'($urandom_range(0, 4));
        end
      end
      write_all(f, lt, sp);
      gap_on   = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      repeat (60) send_random_item();
    end
    wait_idle();

    if (sb.bad_fields == 0 && sb.pending() == 0) begin
      $display("key_debounce_event_fifo_core: match");
    end else begin
      $display("key_debounce_event_fifo_core: mismatch");
    end
    $finish;
  end

endmodule
